// ===== rtl/nen_pkg.sv =====
// ----------------------------------------------------------------------------
// nen_pkg - normalised euclidean norm, shared definitions
// Widths of the fixed-point path and the request/result structs.
// ----------------------------------------------------------------------------
package nen_pkg;

  localparam int SIZE_W     = 16;                  // element size and normaliser
  localparam int FRAC_BITS  = 8;                   // fraction bits of quotient and norm
  localparam int QUOT_W     = SIZE_W + FRAC_BITS;  // Q16.FRAC quotient
  localparam int SQ_W       = 2 * QUOT_W;          // squared quotient
  localparam int SUM_W      = 56;                  // saturating accumulator
  localparam int NORM_W     = 26;                  // result width
  localparam int DIV_CNT_W  = $clog2(QUOT_W);

  typedef struct packed {
    logic [SIZE_W-1:0] element_size;
    logic [SIZE_W-1:0] normalizer;
    logic              is_last;
  } request_t;

  typedef struct packed {
    logic [NORM_W-1:0] norm_value;
    logic              divide_error;
  } result_t;

endpackage

// ===== rtl/normalized_euclidean_norm.sv =====
// ----------------------------------------------------------------------------
// normalized_euclidean_norm - L2 norm of normalised vector elements
// Bit-serial divide, square and accumulate per element; bit-pair root at end.
// ----------------------------------------------------------------------------
// Usage:
//   A request (one vector element) is taken on a rising edge with start high
//   and busy low. Each element is divided by its normaliser into Q16.8 by a
//   restoring divider, one quotient bit per cycle; the square is built up
//   alongside from the quotient bits, so no multiplier is needed.
//   Each element is accepted, divided, then accumulated; busy is high from
//   the accepting edge until the element is through.
//   On the element marked is_last a bit-pair square root of the 56-bit sum
//   follows the accumulate step.
//   The result then appears on result for exactly one cycle with done high,
//   the first cycle with busy low again; a new request may be taken in it.
//   There is no back-pressure: the receiver must take result when done is
//   high. A zero normaliser counts as a zero quotient and flags
//   divide_error for the whole vector, with norm_value forced to zero.
//   The sum saturates at all ones and norm_value saturates at 2^26-1.
//   rst (synchronous, active high) drops busy and done and clears the sum
//   and the error flag, ready for a fresh vector.
// ----------------------------------------------------------------------------
module normalized_euclidean_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  nen_pkg::request_t   request,
  output logic                busy,
  output logic                done,
  output nen_pkg::result_t    result
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_ROOT = 4'b1000
  } state_t;

  state_t state;

  // divider
  logic [nen_pkg::QUOT_W-1:0]    dividend;   // shifts out MSB first
  logic [nen_pkg::SIZE_W-1:0]    divisor;
  logic [nen_pkg::SIZE_W-1:0]    rem;
  logic [nen_pkg::QUOT_W-1:0]    quot;
  logic [nen_pkg::SQ_W-1:0]      sq;         // quot * quot, built bit by bit
  logic [nen_pkg::DIV_CNT_W-1:0] div_count;
  logic                          last;

  // accumulator and flags
  logic [nen_pkg::SUM_W-1:0]     sum;
  logic                          err;

  // square root
  logic [nen_pkg::SUM_W-1:0]     rad;
  logic [nen_pkg::SUM_W-1:0]     root;
  logic [nen_pkg::SUM_W-1:0]     bit_mask;

  logic [nen_pkg::SIZE_W:0]      rem_shift;
  logic                          q_bit;
  logic [nen_pkg::SIZE_W:0]      rem_diff;
  logic [nen_pkg::SQ_W-1:0]      sq_next;
  logic [nen_pkg::SUM_W:0]       sum_add;
  logic [nen_pkg::SUM_W-1:0]     sum_next;
  logic [nen_pkg::SUM_W-1:0]     trial;
  logic                          root_ge;
  logic [nen_pkg::SUM_W-1:0]     root_next;
  logic [nen_pkg::NORM_W-1:0]    norm_sat;

  assign busy = (state != ST_IDLE);

  // Restoring divide step; a zero divisor yields zero quotient bits.
  always_comb begin
    rem_shift = {rem, dividend[nen_pkg::QUOT_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    q_bit     = (rem_shift >= {1'b0, divisor}) && (divisor != '0);
    // (2q+b)^2 = 4q^2 + b(4q+1)
    sq_next   = {sq[nen_pkg::SQ_W-3:0], 2'b00}
              + (q_bit ? nen_pkg::SQ_W'({quot, 2'b01}) : '0);
  end

  // Saturating accumulate
  always_comb begin
    sum_add  = {1'b0, sum} + (nen_pkg::SUM_W+1)'(sq);
    sum_next = sum_add[nen_pkg::SUM_W] ? '1 : sum_add[nen_pkg::SUM_W-1:0];
  end

  // Bit-pair square root step
  always_comb begin
    trial     = root + bit_mask;
    root_ge   = (rad >= trial);
    root_next = root_ge ? ((root >> 1) + bit_mask) : (root >> 1);
    norm_sat  = (root_next[nen_pkg::SUM_W-1:nen_pkg::NORM_W] != '0) ? '1
              : root_next[nen_pkg::NORM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      sum   <= '0;
      err   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            dividend  <= {request.element_size, nen_pkg::FRAC_BITS'(0)};
            divisor   <= request.normalizer;
            last      <= request.is_last;
            rem       <= '0;
            quot      <= '0;
            sq        <= '0;
            div_count <= nen_pkg::DIV_CNT_W'(nen_pkg::QUOT_W - 1);
            err       <= err | (request.normalizer == '0);
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          dividend <= {dividend[nen_pkg::QUOT_W-2:0], 1'b0};
          rem      <= q_bit ? rem_diff[nen_pkg::SIZE_W-1:0]
                            : rem_shift[nen_pkg::SIZE_W-1:0];
          quot     <= {quot[nen_pkg::QUOT_W-2:0], q_bit};
          sq       <= sq_next;
          div_count <= div_count - 1'b1;
          if (div_count == '0) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (last) begin
            rad      <= sum_next;
            root     <= '0;
            bit_mask <= nen_pkg::SUM_W'(1) << (nen_pkg::SUM_W - 2);
            state    <= ST_ROOT;
          end else begin
            sum   <= sum_next;
            state <= ST_IDLE;
          end
        end
        ST_ROOT: begin
          rad      <= root_ge ? (rad - trial) : rad;
          root     <= root_next;
          bit_mask <= bit_mask >> 2;
          if (bit_mask[0]) begin
            result.norm_value   <= err ? '0 : norm_sat;
            result.divide_error <= err;
            done  <= 1'b1;
            sum   <= '0;
            err   <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_after_root: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_ROOT))
    else $error("done without a finished root");

  a_err_zero_norm: assert property (@(posedge clk) disable iff (rst)
    (done && result.divide_error) |-> (result.norm_value == '0))
    else $error("error result with non-zero norm");

  a_start_to_div: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_DIV))
    else $error("accepted request did not start the divider");

  a_root_mask: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> $onehot(bit_mask))
    else $error("root bit mask lost its single bit");

endmodule
